// ----- hw/rtl/i2c_register_access_master_top_macros.svh -----
// Assertion macros shared by the I2C register access master RTL.
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2CRM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2CRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/i2crm_pkg.sv -----
// Types and constants for the I2C register access master.
package i2crm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START     = 5'd1,
    PH_SEND_DEV  = 5'd2,
    PH_ACK_DEV   = 5'd3,
    PH_SEND_REG  = 5'd4,
    PH_ACK_REG   = 5'd5,
    PH_SEND_DATA = 5'd6,
    PH_ACK_DATA  = 5'd7,
    PH_RSTART    = 5'd8,
    PH_SEND_DEVR = 5'd9,
    PH_ACK_DEVR  = 5'd10,
    PH_READ      = 5'd11,
    PH_NOACK     = 5'd12,
    PH_STOP      = 5'd13,
    PH_RECOVER   = 5'd14
  } phase_t;

  // Configuration register indexes
  localparam logic CFG_RECOVERY  = 1'b0;
  localparam logic CFG_ACK_LIMIT = 1'b1;

  localparam logic [19:0] RECOVERY_RESET  = 20'd10000;
  localparam logic [15:0] ACK_LIMIT_RESET = 16'd0;
  localparam logic [19:0] WAIT_MAX        = 20'hFFFFF;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  typedef struct packed {
    logic       go;
    logic       mode;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic        half_step;
    logic [2:0]  bit_index;
    logic [7:0]  shift_byte;
    logic        held_mode;
    logic [6:0]  held_device;
    logic [7:0]  held_register;
    logic [7:0]  held_data;
    logic [19:0] wait_count;
    logic        error_seen;
  } seq_state_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } result_t;

endpackage

// ----- hw/rtl/i2crm_step.sv -----
// One bus tick of the I2C transaction sequencer: next state and line levels.
module i2crm_step (
  input  i2crm_pkg::seq_state_t st_i,
  input  i2crm_pkg::item_t      item_i,
  input  logic [19:0]           recovery_ticks_i,
  input  logic [15:0]           ack_wait_limit_i,
  output i2crm_pkg::seq_state_t st_o,
  output i2crm_pkg::result_t    res_o
);

  logic [20:0] wait_inc;
  logic        bit_out;
  logic        ack_timeout;
  logic        recover_end;
  logic        finish;
  logic [7:0]  mask;

  function automatic i2crm_pkg::seq_state_t enter(i2crm_pkg::seq_state_t s,
                                                  i2crm_pkg::phase_t p);
    i2crm_pkg::seq_state_t r;
    r            = s;
    r.phase      = p;
    r.half_step  = 1'b0;
    r.bit_index  = 3'd0;
    r.wait_count = '0;
    return r;
  endfunction

  assign wait_inc    = {1'b0, st_i.wait_count} + 21'd1;
  assign mask        = 8'h80 >> st_i.bit_index;
  assign bit_out     = st_i.shift_byte[3'd7 - st_i.bit_index];
  assign ack_timeout = (ack_wait_limit_i != 16'd0) && (wait_inc >= {5'd0, ack_wait_limit_i});
  assign recover_end = wait_inc >= {1'b0, recovery_ticks_i};

  always_comb begin
    st_o           = st_i;
    finish         = 1'b0;
    res_o.scl_out  = 1'b1;
    res_o.sda_out  = 1'b1;
    res_o.busy_res = 1'b1;
    res_o.done_res = 1'b0;
    res_o.read_data = 8'd0;
    res_o.ack_error = 1'b0;

    unique case (st_i.phase)
      i2crm_pkg::PH_IDLE: begin
        res_o.busy_res = 1'b0;
        if (item_i.go) begin
          st_o               = enter(st_i, i2crm_pkg::PH_START);
          st_o.held_mode     = item_i.mode;
          st_o.held_device   = item_i.device_address;
          st_o.held_register = item_i.register_address;
          st_o.held_data     = item_i.write_data;
          st_o.error_seen    = 1'b0;
          res_o.busy_res     = 1'b1;
        end
      end
      i2crm_pkg::PH_START, i2crm_pkg::PH_RSTART: begin
        res_o.scl_out = (st_i.bit_index != 3'd0);
        res_o.sda_out = (st_i.bit_index != 3'd2);
        if (st_i.bit_index >= 3'd2) begin
          if (st_i.phase == i2crm_pkg::PH_RSTART) begin
            st_o            = enter(st_i, i2crm_pkg::PH_SEND_DEVR);
            st_o.shift_byte = {st_i.held_device, 1'b1};
          end else begin
            st_o            = enter(st_i, i2crm_pkg::PH_SEND_DEV);
            st_o.shift_byte = {st_i.held_device, 1'b0};
          end
        end else begin
          st_o.bit_index = st_i.bit_index + 3'd1;
        end
      end
      i2crm_pkg::PH_SEND_DEV, i2crm_pkg::PH_SEND_REG,
      i2crm_pkg::PH_SEND_DATA, i2crm_pkg::PH_SEND_DEVR: begin
        res_o.sda_out = bit_out;
        res_o.scl_out = st_i.half_step;
        if (!st_i.half_step) begin
          st_o.half_step = 1'b1;
        end else if (st_i.bit_index == 3'd7) begin
          case (st_i.phase)
            i2crm_pkg::PH_SEND_DEV:  st_o = enter(st_i, i2crm_pkg::PH_ACK_DEV);
            i2crm_pkg::PH_SEND_REG:  st_o = enter(st_i, i2crm_pkg::PH_ACK_REG);
            i2crm_pkg::PH_SEND_DATA: st_o = enter(st_i, i2crm_pkg::PH_ACK_DATA);
            default:                 st_o = enter(st_i, i2crm_pkg::PH_ACK_DEVR);
          endcase
        end else begin
          st_o.half_step = 1'b0;
          st_o.bit_index = st_i.bit_index + 3'd1;
        end
      end
      i2crm_pkg::PH_ACK_DEV, i2crm_pkg::PH_ACK_REG,
      i2crm_pkg::PH_ACK_DATA, i2crm_pkg::PH_ACK_DEVR: begin
        if (!st_i.half_step) begin
          res_o.scl_out  = 1'b0;
          st_o.half_step = 1'b1;
        end else if (!item_i.sda_in) begin
          case (st_i.phase)
            i2crm_pkg::PH_ACK_DEV: begin
              st_o            = enter(st_i, i2crm_pkg::PH_SEND_REG);
              st_o.shift_byte = st_i.held_register;
            end
            i2crm_pkg::PH_ACK_REG: begin
              if (st_i.held_mode) begin
                st_o = enter(st_i, i2crm_pkg::PH_RSTART);
              end else begin
                st_o            = enter(st_i, i2crm_pkg::PH_SEND_DATA);
                st_o.shift_byte = st_i.held_data;
              end
            end
            i2crm_pkg::PH_ACK_DATA: st_o = enter(st_i, i2crm_pkg::PH_STOP);
            default: begin
              st_o            = enter(st_i, i2crm_pkg::PH_READ);
              st_o.shift_byte = 8'd0;
            end
          endcase
        end else if (ack_timeout) begin
          st_o            = enter(st_i, i2crm_pkg::PH_STOP);
          st_o.error_seen = 1'b1;
        end else if (st_i.wait_count < i2crm_pkg::WAIT_MAX) begin
          st_o.wait_count = wait_inc[19:0];
        end
      end
      i2crm_pkg::PH_READ: begin
        res_o.scl_out = st_i.half_step;
        if (!st_i.half_step) begin
          st_o.half_step = 1'b1;
        end else begin
          if (item_i.sda_in) st_o.shift_byte = st_i.shift_byte | mask;
          st_o.half_step = 1'b0;
          if (st_i.bit_index == 3'd7) begin
            st_o            = enter(st_o, i2crm_pkg::PH_NOACK);
          end else begin
            st_o.bit_index = st_i.bit_index + 3'd1;
          end
        end
      end
      i2crm_pkg::PH_NOACK: begin
        res_o.scl_out = st_i.half_step;
        if (!st_i.half_step) st_o.half_step = 1'b1;
        else st_o = enter(st_i, i2crm_pkg::PH_STOP);
      end
      i2crm_pkg::PH_STOP: begin
        res_o.scl_out = (st_i.bit_index != 3'd0);
        res_o.sda_out = (st_i.bit_index == 3'd2);
        if (st_i.bit_index >= 3'd2) begin
          if (!st_i.held_mode && recovery_ticks_i != 20'd0) begin
            st_o = enter(st_i, i2crm_pkg::PH_RECOVER);
          end else begin
            finish = 1'b1;
          end
        end else begin
          st_o.bit_index = st_i.bit_index + 3'd1;
        end
      end
      i2crm_pkg::PH_RECOVER: begin
        if (recover_end) finish = 1'b1;
        else st_o.wait_count = wait_inc[19:0];
      end
      default: begin
        // unused phase code: back to idle with lines released
        res_o.busy_res = 1'b0;
        st_o           = enter(st_i, i2crm_pkg::PH_IDLE);
      end
    endcase

    if (finish) begin
      res_o.done_res  = 1'b1;
      res_o.ack_error = st_i.error_seen;
      res_o.read_data = (st_i.held_mode && !st_i.error_seen) ? st_i.shift_byte : 8'd0;
      st_o            = enter(st_o, i2crm_pkg::PH_IDLE);
    end
  end

endmodule

// ----- hw/rtl/i2c_register_access_master_top.sv -----
// Top level of the I2C register access master: beat pipeline around the sequencer.
//
//  channel  dir  handshake                 payload
//  in_      in   in_tvalid / in_tready     in_tdata (go, addresses, data, sda_in), in_tuser (mode)
//  out_     out  out_tvalid / out_tready   out_tdata (scl, sda, busy, done, read_data, ack_error)
//  cfg_     in   cfg_valid / cfg_ready     cfg_addr (register index), cfg_data
//
//  One input beat is one bus tick and yields exactly one output beat.
//  Sustained rate is one beat per clock while out_tready holds high; a beat passes
//  through the input register, then the sequencer step into the result register.
//  A stalled out_tready holds the result register; the input register takes one
//  more beat only if it is empty, then in_tready drops.
//  rst_n is synchronous, active low; it returns the sequencer to idle and loads
//  the register reset values. cfg_ready is always high.
`include "i2c_register_access_master_top_macros.svh"

module i2c_register_access_master_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] go, [7:1] device_address, [15:8] register_address,
  // [23:16] write_data, [24] sda_in, [31:25] zero
  input  logic [31:0] in_tdata,
  // [0] mode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
  // [11:4] read_data, [12] ack_error, [15:13] zero
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [19:0] cfg_data
);

  logic                  in_valid_r;
  i2crm_pkg::item_t      in_item_r;
  logic                  out_valid_r;
  i2crm_pkg::result_t    res_r;
  i2crm_pkg::seq_state_t state_r;
  i2crm_pkg::seq_state_t state_nxt;
  i2crm_pkg::result_t    res_nxt;
  logic [19:0]           recovery_ticks_r;
  logic [15:0]           ack_wait_limit_r;
  logic                  adv_ok;
  logic                  fire;
  i2crm_pkg::item_t      in_item;

  assign adv_ok    = !out_valid_r || out_tready;
  assign fire      = in_valid_r && adv_ok;
  assign in_tready = !in_valid_r || adv_ok;
  assign cfg_ready = 1'b1;

  assign in_item.go               = in_tdata[0];
  assign in_item.mode             = in_tuser;
  assign in_item.device_address   = in_tdata[7:1];
  assign in_item.register_address = in_tdata[15:8];
  assign in_item.write_data       = in_tdata[23:16];
  assign in_item.sda_in           = in_tdata[24];

  i2crm_step u_step (
    .st_i             (state_r),
    .item_i           (in_item_r),
    .recovery_ticks_i (recovery_ticks_r),
    .ack_wait_limit_i (ack_wait_limit_r),
    .st_o             (state_nxt),
    .res_o            (res_nxt)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r               <= 1'b0;
      out_valid_r              <= 1'b0;
      // all-zero state is the idle phase
      state_r                  <= '0;
      recovery_ticks_r         <= i2crm_pkg::RECOVERY_RESET;
      ack_wait_limit_r         <= i2crm_pkg::ACK_LIMIT_RESET;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv_ok) out_valid_r <= in_valid_r;
      if (fire) state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_addr)
          i2crm_pkg::CFG_RECOVERY:  recovery_ticks_r <= cfg_data;
          i2crm_pkg::CFG_ACK_LIMIT: ack_wait_limit_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_item_r <= in_item;
    if (fire) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, res_r.ack_error, res_r.read_data, res_r.done_res,
                       res_r.busy_res, res_r.sda_out, res_r.scl_out};

  `I2CRM_ASSERT_IMPL(a_done_busy, out_valid_r && res_r.done_res, res_r.busy_res,
                     "done without busy")
  `I2CRM_ASSERT_IMPL(a_err_done, out_valid_r && res_r.ack_error, res_r.done_res,
                     "ack_error off the done beat")
  `I2CRM_ASSERT_IMPL(a_rdata_done, out_valid_r && (res_r.read_data != 8'd0),
                     res_r.done_res && !res_r.ack_error, "read_data outside a good done beat")
  `I2CRM_ASSERT_NEXT(a_idle_hold,
                     fire && (state_r.phase == i2crm_pkg::PH_IDLE) && !in_item_r.go,
                     state_r.phase == i2crm_pkg::PH_IDLE, "left idle without go")
  `I2CRM_ASSERT_NEXT(a_done_idle, fire && res_nxt.done_res,
                     (state_r.phase == i2crm_pkg::PH_IDLE) && out_valid_r && res_r.done_res,
                     "done did not return to idle")

endmodule
